[design/pli_pkg.sv]
// Shared constants, codes and types of the positional list engine.
`timescale 1ns / 1ps
package pli_pkg;

    localparam int CAPACITY  = 128;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = 8;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 8;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP       = 8;
    localparam int NGRP      = (CAPACITY + GRP - 1) / GRP;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             tap;
        logic [POS_W-1:0] pos;
        t_word            val;
    } t_cell_ctl;

endpackage

[design/pli_in_if.sv]
// Request channel: operation, position and value with a valid/ready handshake.
`timescale 1ns / 1ps
interface pli_in_if;
    import pli_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [POS_W-1:0]    position;
    logic [WORD_W-1:0]   value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

[design/pli_out_if.sv]
// Result channel: status, read value and entry count with a valid/ready handshake.
`timescale 1ns / 1ps
interface pli_out_if;
    import pli_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_value;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output read_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_count,
                    output ready);
endinterface

[design/pli_cell.sv]
// One list cell: holds one entry and shifts it to or from its neighbors.
`timescale 1ns / 1ps
module pli_cell
    import pli_pkg::*;
(
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctl        i_ctl,
    input  t_word            i_left,
    input  t_word            i_right,
    output t_word            o_entry,
    output t_word            o_tap
);

    t_word            r_entry;
    t_word            n_entry;
    t_word            r_tap;
    logic [CMP_W-1:0] w_idx;
    logic [CMP_W-1:0] w_pos;

    assign w_idx = CMP_W'(i_index);
    assign w_pos = CMP_W'(i_ctl.pos);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (w_idx == w_pos) begin
                n_entry = i_ctl.val;
            end else if (w_idx > w_pos) begin
                n_entry = i_left;
            end
        end else if (i_ctl.del && (w_idx >= w_pos)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_tap   <= (i_ctl.tap && (w_idx == w_pos)) ? r_entry : '0;
    end

    assign o_entry = r_entry;
    assign o_tap   = r_tap;

endmodule

[design/pli_gather.sv]
// Registered OR tree that collects the single selected cell tap.
`timescale 1ns / 1ps
module pli_gather
    import pli_pkg::*;
(
    input  logic  i_clk,
    input  t_word i_taps [CAPACITY],
    output t_word o_word
);

    t_word r_grp [NGRP];
    t_word n_grp [NGRP];

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < CAPACITY) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GRP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_grp[g] <= n_grp[g];
        end
    end

    always_comb begin
        o_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_word = o_word | r_grp[g];
        end
    end

endmodule

[design/positional_list_insert_delete.sv]
// Top level of the positional list engine: control, cell chain and result register.
`timescale 1ns / 1ps
// A bounded ordered list of signed 32-bit words held in a chain of cells, one entry
// per cell; insert and delete shift every later entry by one place at once, in the
// execute cycle. One transaction is handled at a time. A request is taken only when
// idle. The execute cycle shifts the chain and captures the addressed cell's entry,
// the next cycle registers the group stage of the OR tree that brings that entry out,
// and the one after loads the result register. The result is held until taken, and
// the next request can be taken in the cycle after that. Entries are not cleared
// after reset or by clear; only entries below the count are ever read.
// read_value is zero unless a read succeeds.
module positional_list_insert_delete
    import pli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pli_in_if.sink     i_in,
    pli_out_if.source  o_out
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_GATHER = 5'b00100,
        S_REDUCE = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [OP_W-1:0]    r_op;
    logic [POS_W-1:0]   r_pos;
    t_word              r_val;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    t_status            r_status;
    t_status            w_status;
    t_word              r_rd;
    logic               w_accept;
    logic [CMP_W-1:0]   w_pos;
    logic [CMP_W-1:0]   w_cnt;
    logic               w_ok;
    t_cell_ctl          w_ctl;
    t_word              w_entry [CAPACITY];
    t_word              w_tap   [CAPACITY];
    t_word              w_gather;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign w_pos = CMP_W'(r_pos);
    assign w_cnt = CMP_W'(r_count);

    // Checks are made on the registered request, full and empty before position.
    always_comb begin
        w_status = ST_OK;
        unique case (r_op)
            OP_CLEAR: begin
                w_status = ST_OK;
            end
            OP_INSERT: begin
                if (w_cnt >= CMP_W'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else if (w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end
            end
            default: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end
            end
        endcase
    end

    assign w_ok = (r_state == S_EXEC) && (w_status == ST_OK);

    always_comb begin
        w_ctl     = '0;
        w_ctl.ins = w_ok && (r_op == OP_INSERT);
        w_ctl.del = w_ok && (r_op == OP_DELETE);
        w_ctl.tap = w_ok && (r_op == OP_READ);
        w_ctl.pos = r_pos;
        w_ctl.val = r_val;
    end

    always_comb begin
        n_count = r_count;
        if (r_state == S_EXEC) begin
            unique case (r_op)
                OP_CLEAR:  n_count = '0;
                OP_INSERT: n_count = w_ok ? r_count + CNT_W'(1) : r_count;
                OP_DELETE: n_count = w_ok ? r_count - CNT_W'(1) : r_count;
                default:   n_count = r_count;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   n_state = w_accept ? S_EXEC : S_IDLE;
            S_EXEC:   n_state = S_GATHER;
            S_GATHER: n_state = S_REDUCE;
            S_REDUCE: n_state = S_OUT;
            S_OUT:    n_state = o_out.ready ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in.operation;
            r_pos <= i_in.position;
            r_val <= i_in.value;
        end
        if (r_state == S_EXEC) begin
            r_status <= w_status;
        end
        if (r_state == S_REDUCE) begin
            r_rd <= w_gather;
        end
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            t_word w_left;
            t_word w_right;
            if (i == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_entry[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_entry[i+1];
            end
            pli_cell u_cell (
                .i_clk   (i_clk),
                .i_index (IDX_W'(i)),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[i]),
                .o_tap   (w_tap[i])
            );
        end
    endgenerate

    pli_gather u_gather (
        .i_clk  (i_clk),
        .i_taps (w_tap),
        .o_word (w_gather)
    );

    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.status      = r_status;
    assign o_out.read_value  = r_rd;
    assign o_out.entry_count = COUNT_W'(r_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("request taken while a result is pending");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (r_status != ST_OK)) |-> (r_rd == '0))
        else $error("failed transaction carries a read value");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted transaction did not start execution");
`endif

endmodule

[test/testbench.sv]
// Self-checking testbench for the positional list engine with a scoreboard class.
`timescale 1ns / 1ps
module testbench;
    import pli_pkg::*;

    typedef struct {
        t_status              status;
        t_word                read_value;
        logic [COUNT_W-1:0]   entry_count;
    } t_list_result;

    typedef enum {FILL, DRAIN, CHURN} t_traffic;

    // Shadow copy of the list; predicts one result per accepted request.
    class list_result_checker;
        t_word        shadow_list[CAPACITY];
        int unsigned  shadow_count;
        t_list_result pending_results[$];
        int unsigned  error_count;

        function new();
            shadow_count = 0;
            error_count  = 0;
        endfunction

        function void note_request(t_op op, logic [POS_W-1:0] pos, t_word val);
            t_list_result want;
            int idx;
            want.status     = ST_OK;
            want.read_value = '0;
            case (op)
                OP_CLEAR: begin
                    shadow_count = 0;
                end
                OP_INSERT: begin
                    if (shadow_count >= CAPACITY) begin
                        want.status = ST_FULL;
                    end else if (pos > shadow_count) begin
                        want.status = ST_RANGE;
                    end else begin
                        for (idx = shadow_count; idx > pos; idx--)
                            shadow_list[idx] = shadow_list[idx-1];
                        shadow_list[pos] = val;
                        shadow_count++;
                    end
                end
                OP_DELETE: begin
                    if (shadow_count == 0) begin
                        want.status = ST_EMPTY;
                    end else if (pos >= shadow_count) begin
                        want.status = ST_RANGE;
                    end else begin
                        for (idx = pos; idx + 1 < shadow_count; idx++)
                            shadow_list[idx] = shadow_list[idx+1];
                        shadow_count--;
                    end
                end
                default: begin
                    if (shadow_count == 0) begin
                        want.status = ST_EMPTY;
                    end else if (pos >= shadow_count) begin
                        want.status = ST_RANGE;
                    end else begin
                        want.read_value = shadow_list[pos];
                    end
                end
            endcase
            want.entry_count = COUNT_W'(shadow_count);
            pending_results.push_back(want);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, t_word read_value,
                                   logic [COUNT_W-1:0] entry_count);
            t_list_result want;
            if (pending_results.size() == 0) begin
                $error("result with no request pending: status %0d read_value %0d count %0d",
                       status, $signed(read_value), entry_count);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                error_count++;
            end
            if (read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d",
                       $signed(want.read_value), $signed(read_value));
                error_count++;
            end
            if (entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
                error_count++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 930;
    localparam int HOLD_CYCLES  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pli_in_if  req_if ();
    pli_out_if rsp_if ();

    positional_list_insert_delete dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    list_result_checker list_check = new();

    int unsigned sender_idle_pct  = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_request     = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: checks each transaction and decides ready for the next cycle.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                list_check.check_result(rsp_if.status, rsp_if.read_value,
                                        rsp_if.entry_count);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    task automatic send_request(input t_op op, input logic [POS_W-1:0] pos, input t_word val);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.position  <= pos;
        req_if.value     <= val;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        list_check.note_request(op, pos, val);
    endtask

    task automatic send_random(input t_traffic traffic);
        int unsigned cnt;
        int unsigned roll;
        int unsigned upper;
        bit          noise;
        t_op         op;
        logic [POS_W-1:0] pos;
        cnt   = list_check.shadow_count;
        roll  = $urandom_range(99);
        noise = 1'b0;
        op    = OP_READ;
        case (traffic)
            FILL: begin
                if (roll < 78)      op = OP_INSERT;
                else if (roll < 88) op = OP_READ;
                else if (roll < 94) op = OP_DELETE;
                else                noise = 1'b1;
            end
            DRAIN: begin
                if (roll < 68)      op = OP_DELETE;
                else if (roll < 84) op = OP_READ;
                else if (roll < 92) op = OP_INSERT;
                else                noise = 1'b1;
            end
            default: begin
                if (roll < 34)      op = OP_INSERT;
                else if (roll < 58) op = OP_DELETE;
                else if (roll < 88) op = OP_READ;
                else if (roll < 91) op = OP_CLEAR;
                else                noise = 1'b1;
            end
        endcase
        if (noise) begin
            op = t_op'($urandom_range(3, 1));
            // Either anywhere in the position field or just past the last legal index.
            if ($urandom_range(1) == 0)
                pos = POS_W'($urandom_range(255));
            else
                pos = POS_W'((op == OP_INSERT) ? cnt + 1 : cnt);
        end else begin
            upper = (op == OP_INSERT) ? cnt : ((cnt == 0) ? 0 : cnt - 1);
            case ($urandom_range(9))
                0:       pos = '0;
                1:       pos = POS_W'(upper);
                default: pos = POS_W'($urandom_range(upper, 0));
            endcase
        end
        send_request(op, pos, t_word'($urandom()));
    endtask

    initial begin
        int unsigned sent;
        int unsigned seg_len;
        int unsigned edge_hits;
        bit          drain_next;
        t_traffic    traffic;

        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.operation <= OP_CLEAR;
        req_if.position  <= '0;
        req_if.value     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, bad positions, word extremes, front/middle/end edits.
        send_request(OP_READ,   8'd0,   32'h1234_5678);
        send_request(OP_DELETE, 8'd0,   32'h0000_0000);
        send_request(OP_INSERT, 8'd1,   32'h0000_0001);
        send_request(OP_INSERT, 8'd255, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 8'd0,   32'h8000_0000);
        send_request(OP_INSERT, 8'd0,   32'h7FFF_FFFF);
        send_request(OP_INSERT, 8'd2,   32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'd1,   32'h0000_0000);
        send_request(OP_READ,   8'd0,   32'hFFFF_FFFF);
        send_request(OP_READ,   8'd1,   32'h0000_0000);
        send_request(OP_READ,   8'd2,   32'hA5A5_5A5A);
        send_request(OP_READ,   8'd3,   32'h0000_0000);
        send_request(OP_READ,   8'd4,   32'h0000_0000);
        send_request(OP_READ,   8'd255, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 8'd4,   32'h0000_0000);
        send_request(OP_DELETE, 8'd1,   32'h0000_0000);
        send_request(OP_DELETE, 8'd0,   32'h0000_0000);
        send_request(OP_DELETE, 8'd1,   32'hFFFF_FFFF);
        send_request(OP_READ,   8'd0,   32'h0000_0000);
        send_request(OP_INSERT, 8'd1,   32'h5555_AAAA);
        send_request(OP_CLEAR,  8'd200, 32'hDEAD_BEEF);
        send_request(OP_READ,   8'd0,   32'h0000_0000);
        send_request(OP_INSERT, 8'd0,   32'h5555_AAAA);
        send_request(OP_READ,   8'd0,   32'h0000_0000);

        sent       = 0;
        seg_len    = 0;
        edge_hits  = 0;
        drain_next = 1'b1;
        traffic    = FILL;
        while (sent < RANDOM_ITEMS) begin
            case ((sent / 50) % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
                default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
            endcase
            // Long receiver hold while requests keep coming, so the input backs up.
            if (sent == 10 || sent == 610)
                hold_request = HOLD_CYCLES;
            send_random(traffic);
            sent++;
            seg_len++;
            case (traffic)
                FILL: begin
                    if (list_check.shadow_count == CAPACITY) edge_hits++;
                    if (edge_hits >= 8 || seg_len >= 400) begin
                        traffic    = CHURN;
                        drain_next = 1'b1;
                        seg_len    = 0;
                        edge_hits  = 0;
                    end
                end
                DRAIN: begin
                    if (list_check.shadow_count == 0) edge_hits++;
                    if (edge_hits >= 8 || seg_len >= 400) begin
                        traffic    = CHURN;
                        drain_next = 1'b0;
                        seg_len    = 0;
                        edge_hits  = 0;
                    end
                end
                default: begin
                    if (seg_len >= 80) begin
                        traffic = drain_next ? DRAIN : FILL;
                        seg_len = 0;
                    end
                end
            endcase
        end
        req_if.valid <= 1'b0;
        receiver_stall_pct = 0;

        while (list_check.pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (list_check.error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
